>>> rtl/core/spq_pkg.sv
package spq_pkg;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_POP_EMPTY  = 2'd1,
		STATUS_PUSH_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

>>> rtl/core/spq_req_if.sv
interface spq_req_if #(
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
);
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic        [VALUE_WIDTH-1:0]    item_value;
	logic signed [PRIORITY_WIDTH-1:0] item_priority;

	modport source (output valid, output cmd, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input cmd, input item_value, input item_priority,
		output ready);
endinterface

>>> rtl/core/spq_rsp_if.sv
interface spq_rsp_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 5
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] popped_value;
	logic [VALUE_WIDTH-1:0] head_value;
	logic                   head_valid;
	logic [COUNT_WIDTH-1:0] entry_count;
	spq_pkg::status_t       status;

	modport source (output valid, output popped_value, output head_value,
		output head_valid, output entry_count, output status, input ready);
	modport sink (input valid, input popped_value, input head_value,
		input head_valid, input entry_count, input status, output ready);
endinterface

>>> rtl/core/spq_cell.sv
module spq_cell #(
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input  logic                             clk,
	input  spq_pkg::cell_ctrl_t              ctrl,
	input  logic        [VALUE_WIDTH-1:0]    new_value,
	input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
	input  logic                             occupied,
	input  logic                             prev_ge,
	input  logic        [VALUE_WIDTH-1:0]    left_value,
	input  logic signed [PRIORITY_WIDTH-1:0] left_priority,
	input  logic        [VALUE_WIDTH-1:0]    right_value,
	input  logic signed [PRIORITY_WIDTH-1:0] right_priority,
	output logic        [VALUE_WIDTH-1:0]    value,
	output logic signed [PRIORITY_WIDTH-1:0] priority_out,
	output logic                             ge,
	output logic        [VALUE_WIDTH-1:0]    next_value
);
	import spq_pkg::*;

	logic        [VALUE_WIDTH-1:0]    value_q;
	logic signed [PRIORITY_WIDTH-1:0] priority_q;
	logic signed [PRIORITY_WIDTH-1:0] next_priority;

	// entry stays ahead of the new one when its priority is greater or equal
	assign ge = occupied && (priority_q >= new_priority);

	always_comb begin
		next_value    = value_q;
		next_priority = priority_q;
		if (ctrl.push) begin
			if (!ge) begin
				if (prev_ge) begin
					next_value    = new_value;
					next_priority = new_priority;
				end else begin
					next_value    = left_value;
					next_priority = left_priority;
				end
			end
		end else if (ctrl.pop) begin
			next_value    = right_value;
			next_priority = right_priority;
		end
	end

	always_ff @(posedge clk) begin
		value_q    <= next_value;
		priority_q <= next_priority;
	end

	assign value        = value_q;
	assign priority_out = priority_q;
endmodule

>>> rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// The result of each command is registered when the command transfers.
// Throughput: one command per cycle while the result side drains; every cell compares and shifts in that cycle.
// A command transfers while the result register is empty or being drained.
// Reset clears the entry count and the result valid; cell contents stay undefined.
module sorted_priority_queue_core #(
	parameter int CAPACITY       = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input logic   clk,
	input logic   arst_n,
	spq_req_if.sink   request,
	spq_rsp_if.source response
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	logic        [VALUE_WIDTH-1:0]    val_w  [CAPACITY];
	logic signed [PRIORITY_WIDTH-1:0] prio_w [CAPACITY];
	logic        [VALUE_WIDTH-1:0]    next_w [CAPACITY];
	logic        [CAPACITY-1:0]       ge_w;

	logic [CW-1:0]    count_q, count_d;
	logic             accept, push_ok, pop_ok, is_push;
	cell_ctrl_t       ctrl;
	status_t          status_d;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] popped_q, head_q;
	logic                   head_valid_q;
	logic [CW-1:0]          count_out_q;
	status_t                status_q;

	assign request.ready = !out_valid_q || response.ready;
	assign accept  = request.valid && request.ready;
	assign is_push = (request.cmd == CMD_PUSH);
	assign push_ok = accept && is_push && (count_q != CAP_CNT);
	assign pop_ok  = accept && !is_push && (count_q != '0);

	assign ctrl.push = push_ok;
	assign ctrl.pop  = pop_ok;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                             prev_ge;
		logic        [VALUE_WIDTH-1:0]    left_value, right_value;
		logic signed [PRIORITY_WIDTH-1:0] left_priority, right_priority;

		if (i == 0) begin : g_first
			assign prev_ge       = 1'b1;
			assign left_value    = request.item_value;
			assign left_priority = request.item_priority;
		end else begin : g_mid
			assign prev_ge       = ge_w[i-1];
			assign left_value    = val_w[i-1];
			assign left_priority = prio_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value    = '0;
			assign right_priority = '0;
		end else begin : g_inner
			assign right_value    = val_w[i+1];
			assign right_priority = prio_w[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH    (VALUE_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk            (clk),
			.ctrl           (ctrl),
			.new_value      (request.item_value),
			.new_priority   (request.item_priority),
			.occupied       (CW'(i) < count_q),
			.prev_ge        (prev_ge),
			.left_value     (left_value),
			.left_priority  (left_priority),
			.right_value    (right_value),
			.right_priority (right_priority),
			.value          (val_w[i]),
			.priority_out   (prio_w[i]),
			.ge             (ge_w[i]),
			.next_value     (next_w[i])
		);
	end

	always_comb begin
		count_d  = count_q;
		status_d = STATUS_OK;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (pop_ok) begin
			count_d = count_q - CW'(1);
		end
		if (accept && is_push && !push_ok) begin
			status_d = STATUS_PUSH_FULL;
		end else if (accept && !is_push && !pop_ok) begin
			status_d = STATUS_POP_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on every command transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q     <= pop_ok ? val_w[0] : '0;
			head_q       <= (count_d != '0) ? next_w[0] : '0;
			head_valid_q <= (count_d != '0);
			count_out_q  <= count_d;
			status_q     <= status_d;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.popped_value = popped_q;
	assign response.head_value   = head_q;
	assign response.head_valid   = head_valid_q;
	assign response.entry_count  = count_out_q;
	assign response.status       = status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted push did not grow the queue");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(response.valid && response.status == STATUS_PUSH_FULL)
		|-> response.entry_count == CAP_CNT)
		else $error("push dropped while queue not full");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> (response.head_valid == (response.entry_count != '0)))
		else $error("head valid disagrees with entry count");
`endif
endmodule

>>> bench/tb.sv
module tb;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int ITEM_TARGET  = 1300;
	localparam int QUIET_LIMIT  = 1000;
	localparam int HOLDOFF_LEN  = 80;
	localparam int REPORT_LIMIT = 40;

	typedef struct {
		logic [31:0] popped_value;
		logic [31:0] head_value;
		logic        head_valid;
		logic [4:0]  entry_count;
		status_t     status;
	} queue_result_t;

	// Sorted-insertion predictor plus the list of results still owed by the block.
	class spq_scoreboard;
		logic [31:0]        held_values[QUEUE_DEPTH];
		logic signed [15:0] held_prios[QUEUE_DEPTH];
		int                 held_count;
		queue_result_t      owed_results[$];
		int                 errors;

		function new();
			held_count = 0;
			errors = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void note_request(cmd_t c, logic [31:0] v, logic signed [15:0] p);
			queue_result_t r;
			int pos;
			int i;
			r.popped_value = '0;
			r.status = STATUS_OK;
			if (c == CMD_PUSH) begin
				if (held_count >= QUEUE_DEPTH) begin
					r.status = STATUS_PUSH_FULL;
				end else begin
					// go behind every entry of greater or equal priority
					pos = 0;
					while (pos < held_count && held_prios[pos] >= p)
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_values[i] = held_values[i-1];
						held_prios[i] = held_prios[i-1];
					end
					held_values[pos] = v;
					held_prios[pos] = p;
					held_count++;
				end
			end else begin
				if (held_count == 0) begin
					r.status = STATUS_POP_EMPTY;
				end else begin
					r.popped_value = held_values[0];
					for (i = 1; i < held_count; i++) begin
						held_values[i-1] = held_values[i];
						held_prios[i-1] = held_prios[i];
					end
					held_count--;
				end
			end
			r.head_value = (held_count > 0) ? held_values[0] : '0;
			r.head_valid = (held_count > 0);
			r.entry_count = held_count[4:0];
			owed_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_response(logic [31:0] popped, logic [31:0] head, logic head_ok,
				logic [4:0] cnt, logic [1:0] stat);
			queue_result_t r;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t: result with no command outstanding, head %h count %0d",
						$time, head, cnt);
				return;
			end
			r = owed_results.pop_front();
			compare_field("popped_value", r.popped_value, popped);
			compare_field("head_value", r.head_value, head);
			compare_field("head_valid", {31'b0, r.head_valid}, {31'b0, head_ok});
			compare_field("entry_count", {27'b0, r.entry_count}, {27'b0, cnt});
			compare_field("status", {30'b0, r.status}, {30'b0, stat});
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_req_if #(.VALUE_WIDTH(32), .PRIORITY_WIDTH(16)) req ();
	spq_rsp_if #(.VALUE_WIDTH(32), .COUNT_WIDTH(5))     rsp ();

	sorted_priority_queue_core #(
		.CAPACITY(QUEUE_DEPTH),
		.VALUE_WIDTH(32),
		.PRIORITY_WIDTH(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req),
		.response(rsp)
	);

	spq_scoreboard sb;
	bit steady;
	int holdoff_asks;
	int holdoff_taken;
	int quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Result side: random back-pressure, plus long hold-offs on request.
	initial begin
		int hold_left;
		rsp.ready = 1'b0;
		holdoff_taken = 0;
		forever begin
			@(negedge clk);
			if (holdoff_asks != holdoff_taken) begin
				holdoff_taken = holdoff_asks;
				rsp.ready <= 1'b0;
				hold_left = HOLDOFF_LEN;
				while (hold_left > 0) begin
					@(negedge clk);
					hold_left--;
				end
			end
			rsp.ready <= steady || ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_response(rsp.popped_value, rsp.head_value, rsp.head_valid,
				rsp.entry_count, rsp.status);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offer one command from a falling edge and hold it until it transfers.
	task automatic send_cmd(cmd_t c, logic [31:0] v, logic signed [15:0] p);
		if (!steady) begin
			while ($urandom_range(99) < 29) begin
				req.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.item_value <= v;
		req.item_priority <= p;
		do @(posedge clk); while (!req.ready);
		sb.note_request(c, v, p);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_priority();
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'(int'($urandom_range(4)) - 2);
			4:          return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default:    return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'h0;
			1:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent;
		int phase;
		int phase_len;
		int push_bias;
		int k;
		cmd_t c;

		sb = new();
		quiet_cycles = 0;
		holdoff_asks = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_PUSH;
		req.item_value = '0;
		req.item_priority = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty pop, priority and value extremes, ties, drain past empty
		send_cmd(CMD_POP, 32'hffff_ffff, 16'sh7fff);
		send_cmd(CMD_PUSH, 32'h0000_0000, 16'sh8000);
		send_cmd(CMD_PUSH, 32'hffff_ffff, 16'sh7fff);
		send_cmd(CMD_PUSH, 32'h0000_00a1, 16'sh0000);
		send_cmd(CMD_PUSH, 32'h0000_00a2, 16'sh0000);
		send_cmd(CMD_PUSH, 32'h0000_00b1, 16'shffff);
		send_cmd(CMD_PUSH, 32'h0000_00c1, 16'sh0001);
		send_cmd(CMD_PUSH, 32'h0000_00a3, 16'sh0000);
		send_cmd(CMD_PUSH, 32'h5555_5555, 16'sh8000);
		send_cmd(CMD_PUSH, 32'haaaa_aaaa, 16'sh7fff);
		for (k = 0; k < 11; k++)
			send_cmd(CMD_POP, $urandom, 16'($urandom));
		sent = 21;

		phase = 0;
		while (sent < ITEM_TARGET) begin
			case ($urandom_range(3))
				0:       push_bias = 90;
				1:       push_bias = 15;
				default: push_bias = 55;
			endcase
			steady = (phase >= 10 && phase < 16);
			// fill hard while the result side holds off
			if (phase == 3 || phase == 22) begin
				push_bias = 95;
				holdoff_asks++;
			end
			phase_len = $urandom_range(20, 60);
			for (k = 0; k < phase_len; k++) begin
				c = ($urandom_range(99) < push_bias) ? CMD_PUSH : CMD_POP;
				send_cmd(c, pick_value(), pick_priority());
				sent++;
			end
			phase++;
		end
		req.valid <= 1'b0;
		steady = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
